@@ hw/rtl/sst_pkg.sv @@
// Package for the scoped symbol table: request and status codes, default sizes,
// stream widths and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

   localparam int SST_SLOTS     = 64;
   localparam int SST_MAX_DEPTH = 15;

   localparam int KEY_W         = 32;
   localparam int VAL_W         = 32;
   localparam int REQ_TDATA_W   = 64;
   localparam int REQ_TUSER_W   = 2;
   localparam int RSP_TDATA_W   = 40;
   localparam int STATUS_W      = 3;

   typedef enum logic [1:0] {
      REQ_OPEN   = 2'd0,
      REQ_CLOSE  = 2'd1,
      REQ_DEFINE = 2'd2,
      REQ_LOOKUP = 2'd3
   } sst_req_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DEFINED   = 3'd1,
      ST_UNDEFINED = 3'd2,
      ST_FULL      = 3'd3,
      ST_DEPTH     = 3'd4
   } sst_status_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic finish;
   } sst_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic last_rd;
   } sst_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/sst_ctrl.sv @@
// Controller for the scoped symbol table: request handshake, slot scan sequencing
// and the response valid flag. Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output sst_pkg::sst_cmd_type  cmd,
   input  sst_pkg::sst_stat_type stat
);
   import sst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   assign cmd.load    = accept;
   assign cmd.scan_rd = (state_ff == S_SCAN);
   assign cmd.finish  = (state_ff == S_FINISH) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= stat.need_scan ? S_SCAN : S_FINISH;
               end
            end
            S_SCAN: begin
               if (stat.last_rd) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while busy");

   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished request produced no response");

   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd && stat.last_rd) |=> !cmd.scan_rd)
      else $error("slot scan ran past the last slot");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sst_dpath.sv @@
// Datapath for the scoped symbol table: slot memory, fill mark, scope depth,
// shared key comparator and response registers. Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_dpath #(
   parameter int SLOTS     = sst_pkg::SST_SLOTS,
   parameter int MAX_DEPTH = sst_pkg::SST_MAX_DEPTH
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [1:0]                    req_type,
   input  wire  [sst_pkg::KEY_W-1:0]     req_key,
   input  wire  [sst_pkg::VAL_W-1:0]     req_bind_value,
   input  sst_pkg::sst_cmd_type          cmd,
   output sst_pkg::sst_stat_type         stat,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sst_pkg::VAL_W-1:0]     rsp_found_value
);
   import sst_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HW = $clog2(SLOTS + 1);
   localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH + 1) : 1;

   typedef struct packed {
      logic          vld;
      logic [LW-1:0] lvl;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
   } word_type;

   word_type         mem [SLOTS];

   sst_req_type      type_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic [LW-1:0]    depth_ff;
   logic [HW-1:0]    hwm_ff;
   logic [AW-1:0]    addr_ff;
   word_type         rd_word_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic             rd_vld_ff;
   logic             hit_ff;
   logic             dup_ff;
   logic             free_ff;
   logic [LW-1:0]    best_lvl_ff;
   logic [VAL_W-1:0] best_val_ff;
   logic [AW-1:0]    free_idx_ff;
   sst_status_type   rsp_status_ff;
   logic [VAL_W-1:0] rsp_found_ff;

   logic             ent_valid;
   logic             key_hit;
   logic             lvl_here;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   word_type         wr_word;
   logic             def_write;
   logic [HW-1:0]    free_next;

   assign stat.need_scan = !((sst_req_type'(req_type) == REQ_OPEN) ||
                             ((sst_req_type'(req_type) == REQ_CLOSE) && (depth_ff == '0)));
   assign stat.last_rd   = (addr_ff == AW'(SLOTS - 1));

   assign ent_valid = rd_vld_ff && rd_word_ff.vld && (HW'(rd_idx_ff) < hwm_ff);
   assign key_hit   = ent_valid && (rd_word_ff.key == key_ff);
   assign lvl_here  = (rd_word_ff.lvl == depth_ff);

   assign def_write = cmd.finish && (type_ff == REQ_DEFINE) && !dup_ff && free_ff;
   assign free_next = HW'(free_idx_ff) + HW'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_word = rd_word_ff;
      if (def_write) begin
         wr_en       = 1'b1;
         wr_addr     = free_idx_ff;
         wr_word.vld = 1'b1;
         wr_word.lvl = depth_ff;
         wr_word.key = key_ff;
         wr_word.val = val_ff;
      end else if ((type_ff == REQ_CLOSE) && ent_valid && lvl_here) begin
         wr_en       = 1'b1;
         wr_word.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_word_ff <= mem[addr_ff];
         rd_idx_ff  <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= sst_req_type'(req_type);
         key_ff  <= req_key;
         val_ff  <= req_bind_value;
      end
      if (key_hit && (!hit_ff || (rd_word_ff.lvl > best_lvl_ff))) begin
         best_lvl_ff <= rd_word_ff.lvl;
         best_val_ff <= rd_word_ff.val;
      end
      if (rd_vld_ff && !ent_valid && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         hwm_ff    <= '0;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         dup_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.load) begin
            addr_ff <= '0;
            hit_ff  <= 1'b0;
            dup_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else begin
            if (cmd.scan_rd) begin
               addr_ff <= addr_ff + AW'(1);
            end
            if (key_hit) begin
               hit_ff <= 1'b1;
            end
            if (key_hit && lvl_here) begin
               dup_ff <= 1'b1;
            end
            if (rd_vld_ff && !ent_valid) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            case (type_ff)
               REQ_OPEN: begin
                  if (depth_ff != LW'(MAX_DEPTH)) begin
                     depth_ff <= depth_ff + LW'(1);
                  end
               end
               REQ_CLOSE: begin
                  if (depth_ff != '0) begin
                     depth_ff <= depth_ff - LW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         if (def_write && (free_next > hwm_ff)) begin
            hwm_ff <= free_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         case (type_ff)
            REQ_OPEN: begin
               rsp_status_ff <= (depth_ff == LW'(MAX_DEPTH)) ? ST_DEPTH : ST_OK;
               rsp_found_ff  <= '0;
            end
            REQ_CLOSE: begin
               rsp_status_ff <= ST_OK;
               rsp_found_ff  <= '0;
            end
            REQ_DEFINE: begin
               if (dup_ff) begin
                  rsp_status_ff <= ST_DEFINED;
               end else if (!free_ff) begin
                  rsp_status_ff <= ST_FULL;
               end else begin
                  rsp_status_ff <= ST_OK;
               end
               rsp_found_ff <= '0;
            end
            REQ_LOOKUP: begin
               rsp_status_ff <= hit_ff ? ST_OK : ST_UNDEFINED;
               rsp_found_ff  <= hit_ff ? best_val_ff : '0;
            end
            default: begin
               rsp_status_ff <= ST_OK;
               rsp_found_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= LW'(MAX_DEPTH))
      else $error("scope depth beyond limit");

   a_hwm_bound: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= HW'(SLOTS))
      else $error("fill mark beyond slot count");

   a_write_order: assert property (@(posedge clock) disable iff (reset)
      def_write |-> (!rd_vld_ff && !cmd.scan_rd))
      else $error("define write overlaps slot scan");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/scoped_symbol_table.sv @@
// Scoped symbol table: open/close scope, define and lookup of 32-bit symbol codes
// over a level-tagged slot memory. A request that scans (define, lookup, and close
// above the global scope) reads one slot per cycle from the single read port of
// the slot memory into one shared key comparator, between its accept, drain and
// finish steps; open and close at the global scope go from accept to finish.
// A fill mark tracks the highest slot ever written, so there is no clearing pass
// after reset. A response waits in an output register while the next request is
// accepted. Depends on sst_pkg, sst_ctrl and sst_dpath.
`timescale 1ns / 1ps
`default_nettype none

module scoped_symbol_table #(
   parameter int SLOTS     = sst_pkg::SST_SLOTS,
   parameter int MAX_DEPTH = sst_pkg::SST_MAX_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // key [31:0], bind_value [63:32]
   input  wire  [sst_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type [1:0]
   input  wire  [sst_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // status [2:0], found_value [34:3], zero [39:35]
   output logic [sst_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import sst_pkg::*;

   sst_cmd_type           cmd;
   sst_stat_type          stat;
   logic [STATUS_W-1:0]   status;
   logic [VAL_W-1:0]      found_value;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sst_dpath #(
      .SLOTS     (SLOTS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_tuser[1:0]),
      .req_key         (req_tdata[KEY_W-1:0]),
      .req_bind_value  (req_tdata[KEY_W +: VAL_W]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (status),
      .rsp_found_value (found_value)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - STATUS_W - VAL_W){1'b0}}, found_value, status};

endmodule

`default_nettype wire
